>>> hw/rtl/index_field_decoder_macros.svh
// Assertion macros used by the top RTL file of the field decoder.
`ifndef INDEX_FIELD_DECODER_MACROS_SVH
`define INDEX_FIELD_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define IFD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("index_field_decoder: assertion failed");

// Check that a condition in one cycle implies another in the next cycle.
`define IFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("index_field_decoder: assertion failed");

`else

`define IFD_ASSERT(lbl, clk, rstn, prop)
`define IFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> hw/rtl/ifd_pkg.sv
`timescale 1ns / 1ps

package ifd_pkg;

  // Field format codes
  localparam logic [2:0] KIND_VINT32 = 3'd0;
  localparam logic [2:0] KIND_VINT64 = 3'd1;
  localparam logic [2:0] KIND_BE16   = 3'd2;
  localparam logic [2:0] KIND_BE32   = 3'd3;
  localparam logic [2:0] KIND_BE64   = 3'd4;
  localparam logic [2:0] KIND_CHAR   = 3'd5;

  // Maximum byte counts of the varint formats
  localparam logic [3:0] VINT32_MAX_BYTES = 4'd5;
  localparam logic [3:0] VINT64_MAX_BYTES = 4'd10;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned BYTE_W  = 8;

  typedef struct packed {
    logic                  valid;
    logic [VALUE_W-1:0]    value;
    logic [KIND_W-1:0]     kind;
    logic                  overlong;
  } res_t;

endpackage

>>> hw/rtl/ifd_core.sv
`timescale 1ns / 1ps

module ifd_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic [ifd_pkg::KIND_W-1:0]      action_i,
  input  logic [ifd_pkg::BYTE_W-1:0]      data_byte_i,
  output ifd_pkg::res_t                   res_o
);

  logic                         active_q, active_d;
  logic [ifd_pkg::KIND_W-1:0]   kind_q, kind_d;
  logic [3:0]                   bytes_q, bytes_d;
  logic [ifd_pkg::VALUE_W-1:0]  acc_q, acc_d;
  logic [1:0]                   need_q, need_d;

  logic [ifd_pkg::KIND_W-1:0]   eff_kind;
  logic [3:0]                   eff_bytes;
  logic [ifd_pkg::VALUE_W-1:0]  eff_acc;
  logic [1:0]                   eff_need;
  logic [3:0]                   bytes_inc;
  logic [5:0]                   shamt;
  logic [3:0]                   limit;
  logic [ifd_pkg::VALUE_W-1:0]  acc_new;
  logic                         fin;
  logic                         flag;

  // A new field starts from a clean state and the format on the input.
  assign eff_kind  = active_q ? kind_q  : action_i;
  assign eff_bytes = active_q ? bytes_q : 4'd0;
  assign eff_acc   = active_q ? acc_q   : '0;
  assign eff_need  = active_q ? need_q  : 2'd0;
  assign bytes_inc = eff_bytes + 4'd1;
  assign shamt     = 6'({2'b00, eff_bytes} * 6'd7);

  function automatic logic [ifd_pkg::VALUE_W-1:0] trim(
    input logic [ifd_pkg::KIND_W-1:0]  k,
    input logic [ifd_pkg::VALUE_W-1:0] v
  );
    logic [ifd_pkg::VALUE_W-1:0] r;
    r = v;
    if (k == ifd_pkg::KIND_VINT32) begin
      r = {32'd0, v[31:0]};
    end else if (k == ifd_pkg::KIND_BE16 || k == ifd_pkg::KIND_CHAR) begin
      r = {48'd0, v[15:0]};
    end
    return r;
  endfunction

  always_comb begin
    active_d = active_q;
    kind_d   = kind_q;
    bytes_d  = bytes_q;
    acc_d    = acc_q;
    need_d   = need_q;
    acc_new  = eff_acc;
    fin      = 1'b0;
    flag     = 1'b0;
    limit    = (eff_kind == ifd_pkg::KIND_VINT32) ? ifd_pkg::VINT32_MAX_BYTES
                                                  : ifd_pkg::VINT64_MAX_BYTES;
    if (step_i) begin
      if (!active_q && action_i > ifd_pkg::KIND_CHAR) begin
        // drop the byte, stay idle
        active_d = 1'b0;
      end else if (!active_q && action_i == ifd_pkg::KIND_CHAR) begin
        kind_d   = ifd_pkg::KIND_CHAR;
        active_d = 1'b1;
        bytes_d  = 4'd0;
        if (!data_byte_i[7]) begin
          acc_new = {57'd0, data_byte_i[6:0]};
          fin     = 1'b1;
        end else if (data_byte_i[7:5] != 3'b111) begin
          acc_d  = {53'd0, data_byte_i[4:0], 6'd0};
          need_d = 2'd1;
        end else begin
          acc_d  = {48'd0, data_byte_i[3:0], 12'd0};
          need_d = 2'd2;
        end
      end else begin
        active_d = 1'b1;
        kind_d   = eff_kind;
        unique case (eff_kind)
          ifd_pkg::KIND_VINT32, ifd_pkg::KIND_VINT64: begin
            acc_new = eff_acc | ({57'd0, data_byte_i[6:0]} << shamt);
            acc_d   = acc_new;
            bytes_d = bytes_inc;
            need_d  = eff_need;
            if (!data_byte_i[7]) begin
              fin = 1'b1;
            end else if (bytes_inc >= limit) begin
              fin  = 1'b1;
              flag = 1'b1;
            end
          end
          ifd_pkg::KIND_BE16, ifd_pkg::KIND_BE32, ifd_pkg::KIND_BE64: begin
            acc_new = {eff_acc[ifd_pkg::VALUE_W-9:0], data_byte_i};
            acc_d   = acc_new;
            bytes_d = bytes_inc;
            need_d  = eff_need;
            if ((eff_kind == ifd_pkg::KIND_BE16 && bytes_inc >= 4'd2) ||
                (eff_kind == ifd_pkg::KIND_BE32 && bytes_inc >= 4'd4) ||
                (eff_kind == ifd_pkg::KIND_BE64 && bytes_inc >= 4'd8)) begin
              fin = 1'b1;
            end
          end
          ifd_pkg::KIND_CHAR: begin
            bytes_d = eff_bytes;
            if (eff_need >= 2'd2) begin
              acc_d  = eff_acc | {52'd0, data_byte_i[5:0], 6'd0};
              need_d = 2'd1;
            end else begin
              acc_new = eff_acc | {58'd0, data_byte_i[5:0]};
              fin     = 1'b1;
            end
          end
          default: begin
            active_d = 1'b0;
          end
        endcase
      end
      if (fin) begin
        active_d = 1'b0;
        bytes_d  = 4'd0;
        need_d   = 2'd0;
        acc_d    = '0;
      end
    end
  end

  always_comb begin
    res_o.valid    = fin;
    res_o.value    = trim(eff_kind, acc_new);
    res_o.kind     = eff_kind;
    res_o.overlong = flag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      kind_q   <= '0;
      bytes_q  <= '0;
      acc_q    <= '0;
      need_q   <= '0;
    end else begin
      active_q <= active_d;
      kind_q   <= kind_d;
      bytes_q  <= bytes_d;
      acc_q    <= acc_d;
      need_q   <= need_d;
    end
  end

endmodule

>>> hw/rtl/index_field_decoder.sv
`timescale 1ns / 1ps
// Byte-serial decoder for varints (32/64-bit), big-endian 16/32/64-bit
// integers and modified UTF-8 characters. One byte enters per item; the format
// code on tuser is sampled on the first byte of each field only. A finished
// field leaves as one item with the zero-extended value, its format code and
// an overlong flag for varints cut off at 5 or 10 bytes. Unused format codes
// between fields drop the byte. Throughput is one byte per cycle while the
// output is not held off. The last byte of a field sits in the input register
// while the combinational decode step works on it, and the result register
// then drives the output. The input stalls only while both registers are full
// and the output is held off.

`include "index_field_decoder_macros.svh"

module index_field_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [63:0] value
  output logic [3:0]  m_axis_tuser_o    // [2:0] kind, [3] overlong
);

  logic                         in_valid_q, in_valid_d;
  logic [ifd_pkg::KIND_W-1:0]   in_act_q;
  logic [ifd_pkg::BYTE_W-1:0]   in_byte_q;
  logic                         out_valid_q, out_valid_d;
  logic [ifd_pkg::VALUE_W-1:0]  out_value_q;
  logic [ifd_pkg::KIND_W-1:0]   out_kind_q;
  logic                         out_over_q;
  logic                         out_space;
  logic                         advance;
  logic                         in_take;
  ifd_pkg::res_t                res;
  logic                         out_is_varint;
  logic                         out_is_narrow;

  assign out_space       = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_space;
  assign s_axis_tready_o = !in_valid_q || out_space;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_space) begin
      out_valid_d = advance && res.valid;
    end
  end

  ifd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .action_i    (in_act_q),
    .data_byte_i (in_byte_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_act_q  <= s_axis_tuser_i;
      in_byte_q <= s_axis_tdata_i;
    end
    if (out_space && advance && res.valid) begin
      out_value_q <= res.value;
      out_kind_q  <= res.kind;
      out_over_q  <= res.overlong;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = {out_over_q, out_kind_q};

  assign out_is_varint = (m_axis_tuser_o[2:0] == ifd_pkg::KIND_VINT32) ||
                         (m_axis_tuser_o[2:0] == ifd_pkg::KIND_VINT64);
  assign out_is_narrow = (m_axis_tuser_o[2:0] == ifd_pkg::KIND_BE16) ||
                         (m_axis_tuser_o[2:0] == ifd_pkg::KIND_CHAR);

  `IFD_ASSERT(a_overlong_varint_only, clk_i, rst_ni, !(m_axis_tvalid_o && m_axis_tuser_o[3]) || out_is_varint)
  `IFD_ASSERT(a_narrow_value_trimmed, clk_i, rst_ni, !(m_axis_tvalid_o && out_is_narrow) || m_axis_tdata_o[63:16] == 48'd0)
  `IFD_ASSERT(a_stall_only_when_full, clk_i, rst_ni, s_axis_tready_o || (in_valid_q && out_valid_q && !m_axis_tready_i))
  `IFD_ASSERT_NEXT(a_result_follows_step, clk_i, rst_ni, advance && res.valid, m_axis_tvalid_o)

endmodule

>>> sim/tb_index_field_decoder.sv
`timescale 1ns / 1ps

module tb_index_field_decoder;

  // Format codes that the block drops between fields
  localparam logic [2:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  localparam int RANDOM_BYTES = 1600;
  localparam int QUIET_FROM   = 1350;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  kind;
    logic        overlong;
  } field_result_t;

  class field_scoreboard;
    bit            active;
    logic [2:0]    kind;
    logic [3:0]    nbytes;
    logic [63:0]   acc;
    logic [1:0]    cont_left;
    field_result_t pending[$];
    int            errors;
    int            matched;
    int            overlong_seen;
    int            dropped;

    function new();
      active = 0;
      kind = ifd_pkg::KIND_VINT32;
      nbytes = '0;
      acc = '0;
      cont_left = '0;
      errors = 0;
      matched = 0;
      overlong_seen = 0;
      dropped = 0;
    endfunction

    function void close_field(logic [63:0] v, logic ov);
      field_result_t r;
      if (kind == ifd_pkg::KIND_VINT32) v[63:32] = '0;
      else if (kind == ifd_pkg::KIND_BE16 || kind == ifd_pkg::KIND_CHAR) v[63:16] = '0;
      r.value = v;
      r.kind = kind;
      r.overlong = ov;
      pending.push_back(r);
      active = 0;
      nbytes = '0;
      cont_left = '0;
      acc = '0;
    endfunction

    // Advance the decoder state by one accepted byte.
    function void note_byte(logic [2:0] act, logic [7:0] b);
      int sh;
      int limit;
      int n;
      if (!active) begin
        if (act > ifd_pkg::KIND_CHAR) begin
          dropped++;
          return;
        end
        active = 1;
        kind = act;
        nbytes = '0;
        acc = '0;
        cont_left = '0;
        if (act == ifd_pkg::KIND_CHAR) begin
          if (!b[7]) begin
            close_field(64'(b[6:0]), 1'b0);
            return;
          end
          if (b[7:5] != 3'b111) begin
            acc = 64'(b[4:0]) << 6;
            cont_left = 2'd1;
          end else begin
            acc = 64'(b[3:0]) << 12;
            cont_left = 2'd2;
          end
          return;
        end
      end
      case (kind)
        ifd_pkg::KIND_VINT32, ifd_pkg::KIND_VINT64: begin
          limit = (kind == ifd_pkg::KIND_VINT32) ? int'(ifd_pkg::VINT32_MAX_BYTES)
                                                 : int'(ifd_pkg::VINT64_MAX_BYTES);
          sh = 7 * int'(nbytes);
          if (sh < 64) acc = acc | (64'(b[6:0]) << sh);
          nbytes = nbytes + 4'd1;
          if (!b[7]) close_field(acc, 1'b0);
          else if (int'(nbytes) >= limit) close_field(acc, 1'b1);
        end
        ifd_pkg::KIND_BE16, ifd_pkg::KIND_BE32, ifd_pkg::KIND_BE64: begin
          n = (kind == ifd_pkg::KIND_BE16) ? 2 : (kind == ifd_pkg::KIND_BE32) ? 4 : 8;
          acc = {acc[55:0], b};
          nbytes = nbytes + 4'd1;
          if (int'(nbytes) >= n) close_field(acc, 1'b0);
        end
        ifd_pkg::KIND_CHAR: begin
          if (cont_left >= 2'd2) begin
            acc = acc | (64'(b[5:0]) << 6);
            cont_left = 2'd1;
          end else begin
            close_field(acc | 64'(b[5:0]), 1'b0);
          end
        end
        default: active = 0;
      endcase
    endfunction

    function void check_result(logic [63:0] v, logic [2:0] k, logic ov);
      field_result_t e;
      bit bad;
      if (pending.size() == 0) begin
        $display("%0t: unexpected item value=%h kind=%0d overlong=%0b", $time, v, k, ov);
        errors++;
        return;
      end
      e = pending.pop_front();
      bad = 0;
      if (v !== e.value) begin
        $display("%0t: value mismatch expected %h actual %h", $time, e.value, v);
        bad = 1;
      end
      if (k !== e.kind) begin
        $display("%0t: kind mismatch expected %0d actual %0d", $time, e.kind, k);
        bad = 1;
      end
      if (ov !== e.overlong) begin
        $display("%0t: overlong mismatch expected %0b actual %0b", $time, e.overlong, ov);
        bad = 1;
      end
      if (bad) errors++;
      else matched++;
      if (e.overlong) overlong_seen++;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = '0;
  logic [2:0]  s_user = '0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [63:0] m_axis_tdata_o;
  logic [3:0]  m_axis_tuser_o;

  field_scoreboard sb = new();
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int bytes_sent = 0;
  int cycle_count = 0;

  index_field_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sb.pending.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Outputs are stable between edges; sample the handshake mid-cycle.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready)
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o[2:0], m_axis_tuser_o[3]);
  end

  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        m_ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic send_byte(input logic [2:0] act, input logic [7:0] b);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= b;
    s_user <= act;
    do @(negedge clk_i); while (!s_axis_tready_o);
    @(posedge clk_i);
    sb.note_byte(act, b);
    bytes_sent++;
  endtask

  task automatic send_random_field();
    logic [2:0] k;
    logic [7:0] b;
    int len;
    bit over;
    int cls;
    k = 3'($urandom_range(0, 5));
    case (k)
      ifd_pkg::KIND_VINT32, ifd_pkg::KIND_VINT64: begin
        len = (k == ifd_pkg::KIND_VINT32) ? $urandom_range(1, 6) : $urandom_range(1, 11);
        over = (k == ifd_pkg::KIND_VINT32) ? (len == 6) : (len == 11);
        if (over) len = len - 1;
        for (int i = 0; i < len; i++) begin
          b[6:0] = ($urandom_range(0, 3) == 0) ? 7'h7F : 7'($urandom);
          b[7] = over || (i != len - 1);
          send_byte((i == 0) ? k : 3'($urandom), b);
        end
      end
      ifd_pkg::KIND_BE16, ifd_pkg::KIND_BE32, ifd_pkg::KIND_BE64: begin
        len = (k == ifd_pkg::KIND_BE16) ? 2 : (k == ifd_pkg::KIND_BE32) ? 4 : 8;
        for (int i = 0; i < len; i++) begin
          cls = $urandom_range(0, 5);
          b = (cls == 0) ? 8'hFF : (cls == 1) ? 8'h00 : 8'($urandom);
          send_byte((i == 0) ? k : 3'($urandom), b);
        end
      end
      default: begin
        cls = $urandom_range(0, 2);
        if (cls == 0) b = 8'($urandom_range(8'h00, 8'h7F));
        else if (cls == 1) b = 8'($urandom_range(8'h80, 8'hDF));
        else b = 8'($urandom_range(8'hE0, 8'hFF));
        send_byte(ifd_pkg::KIND_CHAR, b);
        for (int i = 0; i < cls; i++) send_byte(3'($urandom), 8'($urandom));
      end
    endcase
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, each format but BE64, drops, cut-off varint, char forms.
    send_byte(ifd_pkg::KIND_VINT32, 8'h00);
    repeat (5) send_byte(ifd_pkg::KIND_VINT32, 8'hFF);
    send_byte(ACT_UNUSED_HI, 8'hAA);
    send_byte(ACT_UNUSED_LO, 8'h55);
    send_byte(ifd_pkg::KIND_VINT64, 8'h80);
    send_byte(ifd_pkg::KIND_BE16, 8'h01);
    send_byte(ifd_pkg::KIND_BE16, 8'hFF);
    send_byte(ACT_UNUSED_HI, 8'hFF);
    send_byte(ifd_pkg::KIND_BE32, 8'h12);
    send_byte(ifd_pkg::KIND_VINT32, 8'h34);
    send_byte(ifd_pkg::KIND_CHAR, 8'h56);
    send_byte(ifd_pkg::KIND_BE64, 8'h78);
    send_byte(ifd_pkg::KIND_CHAR, 8'h7F);
    send_byte(ifd_pkg::KIND_CHAR, 8'hC3);
    send_byte(ifd_pkg::KIND_CHAR, 8'hA9);
    send_byte(ifd_pkg::KIND_CHAR, 8'h80);
    send_byte(ifd_pkg::KIND_VINT32, 8'hFF);
    send_byte(ifd_pkg::KIND_CHAR, 8'hEF);
    send_byte(ifd_pkg::KIND_CHAR, 8'hBF);
    send_byte(ifd_pkg::KIND_CHAR, 8'hBF);

    // Stall the output long enough that the block backs up onto its input.
    hold_req = 1'b1;
    repeat (40) send_byte(ifd_pkg::KIND_CHAR, 8'($urandom_range(0, 127)));

    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      if (bytes_sent >= QUIET_FROM) idle_on = 1'b0;
      if ($urandom_range(0, 9) == 0)
        send_byte(($urandom_range(0, 1) == 0) ? ACT_UNUSED_LO : ACT_UNUSED_HI,
                  8'($urandom));
      send_random_field();
    end

    s_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("checked %0d fields of all six formats, %0d cut off as overlong, %0d bytes dropped",
             sb.matched, sb.overlong_seen, sb.dropped);
    $display("random traffic with gaps on both sides, one long output stall, %0d errors",
             sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
